FILE: hw/rtl/triangle_tangent_bitangent_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triangle tangent/bitangent block
// Shared concurrent assertion forms, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_BITANGENT_TOP_DEFINES_SVH
`define TRIANGLE_TANGENT_BITANGENT_TOP_DEFINES_SVH

// Same-cycle implication.
`define TTB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg
// Types, widths and helpers shared by the tangent/bitangent block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttb_pkg;

    localparam int COORD_W  = 32;
    localparam int DIFF_W   = 31;
    localparam int PROD_W   = 62;
    localparam int ACC_W    = 64;
    localparam int MAG_W    = 62;
    localparam int SLOT_W   = 16;
    localparam int COMP_W   = 16;
    localparam int IN_W     = 176;
    localparam int OUT_W    = 144;

    // Input word field offsets.
    localparam int OFS_SLOT = 0;
    localparam int OFS_POS  = 16;
    localparam int OFS_TEX  = 112;

    // Queue between front and back.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    // Normalizer iteration counts.
    localparam int SQRT_STEPS = 31;
    localparam int QUO_BITS   = 15;
    localparam int FRAC_BITS  = 14;

    typedef struct packed {
        logic signed [2:0][DIFF_W-1:0] e1;
        logic signed [2:0][DIFF_W-1:0] e2;
        logic signed [DIFF_W-1:0]      du1;
        logic signed [DIFF_W-1:0]      dv1;
        logic signed [DIFF_W-1:0]      du2;
        logic signed [DIFF_W-1:0]      dv2;
        logic [2:0][SLOT_W-1:0]        slot;
    } t_tri;

    typedef struct packed {
        logic                   degenerate;
        logic [2:0][SLOT_W-1:0] slot;
        logic [2:0][COMP_W-1:0] bitan;
        logic [2:0][COMP_W-1:0] tan;
    } t_result;

    typedef struct packed {
        logic                  start;
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
    } t_norm_req;

    typedef struct packed {
        logic                   done;
        logic                   zero;
        logic [2:0][COMP_W-1:0] comp;
    } t_norm_rsp;

    // Exact difference, then divide by 4 rounding toward minus infinity.
    function automatic logic signed [DIFF_W-1:0] quarter_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[COORD_W:2];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ttb_front.sv
// ----------------------------------------------------------------------------
// ttb_front
// Collects corners, forms edges and texture deltas on every third word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttb_front #(
    parameter int SLOT_BITS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire [ttb_pkg::IN_W-1:0]     i_data,
    output logic                        o_push,
    input  wire                         i_push_ready,
    output ttb_pkg::t_tri               o_tri
);

    localparam int SW = (SLOT_BITS < ttb_pkg::SLOT_W) ? SLOT_BITS : ttb_pkg::SLOT_W;
    localparam logic [ttb_pkg::SLOT_W:0] SLOT_MASK =
        (ttb_pkg::SLOT_W+1)'((64'd1 << SW) - 64'd1);

    localparam logic [1:0] CORNER_FIRST  = 2'd0;
    localparam logic [1:0] CORNER_SECOND = 2'd1;
    localparam logic [1:0] CORNER_THIRD  = 2'd2;

    logic [1:0] r_cnt;
    logic       w_accept;

    logic signed [ttb_pkg::COORD_W-1:0] r_pos0 [3];
    logic signed [ttb_pkg::COORD_W-1:0] r_pos1 [3];
    logic signed [ttb_pkg::COORD_W-1:0] r_tex0 [2];
    logic signed [ttb_pkg::COORD_W-1:0] r_tex1 [2];
    logic [ttb_pkg::SLOT_W-1:0]         r_slot0;
    logic [ttb_pkg::SLOT_W-1:0]         r_slot1;

    logic signed [ttb_pkg::COORD_W-1:0] w_pos [3];
    logic signed [ttb_pkg::COORD_W-1:0] w_tex [2];
    logic [ttb_pkg::SLOT_W-1:0]         w_slot;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_pos[k] = i_data[ttb_pkg::OFS_POS + ttb_pkg::COORD_W*k +: ttb_pkg::COORD_W];
        end
        for (int k = 0; k < 2; k++) begin
            w_tex[k] = i_data[ttb_pkg::OFS_TEX + ttb_pkg::COORD_W*k +: ttb_pkg::COORD_W];
        end
        w_slot = i_data[ttb_pkg::OFS_SLOT +: ttb_pkg::SLOT_W] & SLOT_MASK[ttb_pkg::SLOT_W-1:0];
    end

    assign o_ready  = (r_cnt != CORNER_THIRD) || i_push_ready;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && (r_cnt == CORNER_THIRD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CORNER_FIRST;
        end else if (w_accept) begin
            r_cnt <= (r_cnt == CORNER_THIRD) ? CORNER_FIRST : r_cnt + 2'd1;
        end
    end

    // Hold the first two corners.
    always_ff @(posedge i_clk) begin
        if (w_accept && r_cnt == CORNER_FIRST) begin
            r_pos0  <= w_pos;
            r_tex0  <= w_tex;
            r_slot0 <= w_slot;
        end
        if (w_accept && r_cnt == CORNER_SECOND) begin
            r_pos1  <= w_pos;
            r_tex1  <= w_tex;
            r_slot1 <= w_slot;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_tri.e1[k] = ttb_pkg::quarter_diff(r_pos1[k], r_pos0[k]);
            o_tri.e2[k] = ttb_pkg::quarter_diff(w_pos[k], r_pos0[k]);
        end
        o_tri.du1     = ttb_pkg::quarter_diff(r_tex1[0], r_tex0[0]);
        o_tri.dv1     = ttb_pkg::quarter_diff(r_tex1[1], r_tex0[1]);
        o_tri.du2     = ttb_pkg::quarter_diff(w_tex[0], r_tex0[0]);
        o_tri.dv2     = ttb_pkg::quarter_diff(w_tex[1], r_tex0[1]);
        o_tri.slot[0] = r_slot0;
        o_tri.slot[1] = r_slot1;
        o_tri.slot[2] = w_slot;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ttb_fifo.sv
// ----------------------------------------------------------------------------
// ttb_fifo
// Two-entry triangle queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttb_fifo (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  ttb_pkg::t_tri   i_data,
    output logic            o_ready,
    input  wire             i_pop,
    output logic            o_valid,
    output ttb_pkg::t_tri   o_data
);

    ttb_pkg::t_tri                      r_mem [ttb_pkg::FIFO_DEPTH];
    logic [ttb_pkg::FIFO_PTR_W-1:0]     r_wr;
    logic [ttb_pkg::FIFO_PTR_W-1:0]     r_rd;
    logic [ttb_pkg::FIFO_CNT_W-1:0]     r_cnt;

    assign o_ready = (r_cnt != ttb_pkg::FIFO_CNT_W'(ttb_pkg::FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ttb_norm.sv
// ----------------------------------------------------------------------------
// ttb_norm
// Iterative vector normalizer: scale, sum of squares, root, three divides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttb_norm (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ttb_pkg::t_norm_req  i_req,
    output ttb_pkg::t_norm_rsp  o_rsp
);

    localparam int MW = ttb_pkg::MAG_W;
    localparam int QW = ttb_pkg::QUO_BITS;
    localparam int FW = ttb_pkg::FRAC_BITS;

    typedef enum logic [2:0] {
        N_IDLE, N_MAX, N_SHIFT, N_SQ, N_SQRT, N_DSET, N_DIV
    } t_state;

    t_state                 r_state;
    logic [MW-1:0]          r_mag [3];
    logic [2:0]             r_neg;
    logic [MW-1:0]          r_m;
    logic [4:0]             r_cnt;
    logic [1:0]             r_ci;
    logic [59:0]            r_prod;
    logic [MW-1:0]          r_sum;
    logic [MW-1:0]          r_rad;
    logic [32:0]            r_rem;
    logic [30:0]            r_root;
    logic [30:0]            r_len;
    logic [30:0]            r_drem;
    logic [QW-1:0]          r_num;
    logic [QW-2:0]          r_q;

    logic [34:0]            w_cur;
    logic [34:0]            w_trial;
    logic                   w_take;
    logic [31:0]            w_dcur;
    logic                   w_dtake;
    logic [QW-1:0]          w_qfull;
    logic [44:0]            w_numer;
    logic [MW-1:0]          w_total;

    always_comb begin
        w_cur   = {r_rem, r_rad[MW-1 -: 2]};
        w_trial = {2'b00, r_root, 2'b01};
        w_take  = (w_cur >= w_trial);
        w_dcur  = {r_drem, r_num[QW-1]};
        w_dtake = (w_dcur >= {1'b0, r_len});
        w_qfull = {r_q, w_dtake};
        w_numer = {1'b0, r_mag[0][29:0], {FW{1'b0}}} + 45'(r_len >> 1);
        w_total = r_sum + MW'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= N_IDLE;
            o_rsp.done <= 1'b0;
        end else begin
            o_rsp.done <= 1'b0;
            unique case (r_state)
                N_IDLE: begin
                    if (i_req.start) begin
                        for (int k = 0; k < 3; k++) begin
                            r_mag[k] <= i_req.mag[k];
                        end
                        r_neg   <= i_req.neg;
                        r_m     <= (i_req.mag[0] > i_req.mag[1]) ? i_req.mag[0] : i_req.mag[1];
                        r_state <= N_MAX;
                    end
                end
                N_MAX: begin
                    r_m     <= (r_m > r_mag[2]) ? r_m : r_mag[2];
                    r_state <= N_SHIFT;
                end
                N_SHIFT: begin
                    // Bring the largest magnitude to exactly 30 bits.
                    if (r_m == '0) begin
                        o_rsp.done <= 1'b1;
                        o_rsp.zero <= 1'b1;
                        r_state    <= N_IDLE;
                    end else if (|r_m[MW-1:38]) begin
                        r_m <= r_m >> 8;
                        for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] >> 8;
                    end else if (|r_m[MW-1:30]) begin
                        r_m <= r_m >> 1;
                        for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] >> 1;
                    end else if (r_m[29:21] == '0) begin
                        r_m <= r_m << 8;
                        for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] << 8;
                    end else if (!r_m[29]) begin
                        r_m <= r_m << 1;
                        for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] << 1;
                    end else begin
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    // Square and rotate, accumulating each registered product in the following cycle.
                    if (r_cnt != 5'd3) begin
                        r_prod   <= r_mag[0][29:0] * r_mag[0][29:0];
                        r_mag[0] <= r_mag[1];
                        r_mag[1] <= r_mag[2];
                        r_mag[2] <= r_mag[0];
                    end
                    if (r_cnt != '0) begin
                        r_sum <= w_total;
                    end
                    if (r_cnt == 5'd3) begin
                        r_rad   <= w_total;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= N_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                N_SQRT: begin
                    // One root bit per cycle.
                    r_rad <= r_rad << 2;
                    if (w_take) begin
                        r_rem  <= 33'(w_cur - w_trial);
                        r_root <= {r_root[29:0], 1'b1};
                    end else begin
                        r_rem  <= w_cur[32:0];
                        r_root <= {r_root[29:0], 1'b0};
                    end
                    if (r_cnt == 5'(ttb_pkg::SQRT_STEPS - 1)) begin
                        r_len   <= w_take ? {r_root[29:0], 1'b1} : {r_root[29:0], 1'b0};
                        r_ci    <= '0;
                        r_state <= N_DSET;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                N_DSET: begin
                    r_drem  <= {1'b0, w_numer[44:QW]};
                    r_num   <= w_numer[QW-1:0];
                    r_cnt   <= '0;
                    r_state <= N_DIV;
                end
                N_DIV: begin
                    // One quotient bit per cycle.
                    r_drem <= w_dtake ? 31'(w_dcur - {1'b0, r_len}) : w_dcur[30:0];
                    r_num  <= r_num << 1;
                    r_q    <= w_qfull[QW-2:0];
                    if (r_cnt == 5'(QW - 1)) begin
                        o_rsp.comp <= {(r_neg[0] ? ttb_pkg::COMP_W'(0) - {1'b0, w_qfull}
                                                 : {1'b0, w_qfull}),
                                       o_rsp.comp[2:1]};
                        r_mag[0] <= r_mag[1];
                        r_mag[1] <= r_mag[2];
                        r_mag[2] <= r_mag[0];
                        r_neg    <= {r_neg[0], r_neg[2:1]};
                        if (r_ci == 2'd2) begin
                            o_rsp.done <= 1'b1;
                            o_rsp.zero <= 1'b0;
                            r_state    <= N_IDLE;
                        end else begin
                            r_ci    <= r_ci + 2'd1;
                            r_state <= N_DSET;
                        end
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ttb_back.sv
// ----------------------------------------------------------------------------
// ttb_back
// Per-triangle sequencer: cross terms on one multiplier, then normalize.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "triangle_tangent_bitangent_top_defines.svh"

module ttb_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_tri_valid,
    input  ttb_pkg::t_tri       i_tri,
    output logic                o_pop,
    output ttb_pkg::t_norm_req  o_norm_req,
    input  ttb_pkg::t_norm_rsp  i_norm_rsp,
    output logic                o_valid,
    input  wire                 i_ready,
    output ttb_pkg::t_result    o_res
);

    localparam int DW = ttb_pkg::DIFF_W;
    localparam int AW = ttb_pkg::ACC_W;
    localparam logic [3:0] LAST_STEP = 4'd14;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_CHECK, S_WAIT_T, S_WAIT_B, S_FIN
    } t_state;

    t_state                         r_state;
    ttb_pkg::t_tri                  r_tri;
    logic [3:0]                     r_step;
    logic signed [ttb_pkg::PROD_W-1:0] r_prod;
    logic signed [AW-1:0]           r_acc;
    logic signed [AW-1:0]           r_det;
    logic signed [AW-1:0]           r_tan [3];
    logic signed [AW-1:0]           r_bit [3];
    ttb_pkg::t_result               r_res;

    logic signed [DW-1:0]           w_a;
    logic signed [DW-1:0]           w_b;
    logic [3:0]                     w_prev;
    logic signed [AW-1:0]           w_diff;

    // Operand schedule: det, three tangent pairs, three bitangent pairs.
    always_comb begin
        case (r_step)
            4'd0:    begin w_a = r_tri.du1; w_b = r_tri.dv2;   end
            4'd1:    begin w_a = r_tri.du2; w_b = r_tri.dv1;   end
            4'd2:    begin w_a = r_tri.dv2; w_b = r_tri.e1[0]; end
            4'd3:    begin w_a = r_tri.dv1; w_b = r_tri.e2[0]; end
            4'd4:    begin w_a = r_tri.dv2; w_b = r_tri.e1[1]; end
            4'd5:    begin w_a = r_tri.dv1; w_b = r_tri.e2[1]; end
            4'd6:    begin w_a = r_tri.dv2; w_b = r_tri.e1[2]; end
            4'd7:    begin w_a = r_tri.dv1; w_b = r_tri.e2[2]; end
            4'd8:    begin w_a = r_tri.du1; w_b = r_tri.e2[0]; end
            4'd9:    begin w_a = r_tri.du2; w_b = r_tri.e1[0]; end
            4'd10:   begin w_a = r_tri.du1; w_b = r_tri.e2[1]; end
            4'd11:   begin w_a = r_tri.du2; w_b = r_tri.e1[1]; end
            4'd12:   begin w_a = r_tri.du1; w_b = r_tri.e2[2]; end
            4'd13:   begin w_a = r_tri.du2; w_b = r_tri.e1[2]; end
            default: begin w_a = '0;        w_b = '0;          end
        endcase
    end

    assign w_prev = r_step - 4'd1;
    assign w_diff = r_acc - AW'(r_prod);

    // Magnitudes and signs for the normalizer, with the sign of det folded in.
    always_comb begin
        logic signed [AW-1:0] c;
        logic [AW-1:0]        mag;
        o_norm_req.start = ((r_state == S_CHECK) && (r_det != '0)) ||
                           ((r_state == S_WAIT_T) && i_norm_rsp.done && !i_norm_rsp.zero);
        for (int k = 0; k < 3; k++) begin
            c   = (r_state == S_CHECK) ? r_tan[k] : r_bit[k];
            mag = c[AW-1] ? AW'(-c) : AW'(c);
            o_norm_req.mag[k] = mag[ttb_pkg::MAG_W-1:0];
            o_norm_req.neg[k] = c[AW-1] ^ r_det[AW-1];
        end
    end

    assign o_pop = (r_state == S_IDLE) && i_tri_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_tri_valid) begin
                        r_tri       <= i_tri;
                        r_res.slot  <= i_tri.slot;
                        r_step      <= '0;
                        r_state     <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= w_a * w_b;
                    if (r_step != '0) begin
                        if (!w_prev[0]) begin
                            r_acc <= AW'(r_prod);
                        end else begin
                            case (w_prev[3:1])
                                3'd0:    r_det    <= w_diff;
                                3'd1:    r_tan[0] <= w_diff;
                                3'd2:    r_tan[1] <= w_diff;
                                3'd3:    r_tan[2] <= w_diff;
                                3'd4:    r_bit[0] <= w_diff;
                                3'd5:    r_bit[1] <= w_diff;
                                default: r_bit[2] <= w_diff;
                            endcase
                        end
                    end
                    if (r_step == LAST_STEP) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_CHECK: begin
                    if (r_det == '0) begin
                        r_res.tan        <= '0;
                        r_res.bitan      <= '0;
                        r_res.degenerate <= 1'b1;
                        r_state          <= S_FIN;
                    end else begin
                        r_state <= S_WAIT_T;
                    end
                end
                S_WAIT_T: begin
                    if (i_norm_rsp.done) begin
                        if (i_norm_rsp.zero) begin
                            r_res.tan        <= '0;
                            r_res.bitan      <= '0;
                            r_res.degenerate <= 1'b1;
                            r_state          <= S_FIN;
                        end else begin
                            r_res.tan <= i_norm_rsp.comp;
                            r_state   <= S_WAIT_B;
                        end
                    end
                end
                S_WAIT_B: begin
                    if (i_norm_rsp.done) begin
                        if (i_norm_rsp.zero) begin
                            r_res.tan        <= '0;
                            r_res.bitan      <= '0;
                            r_res.degenerate <= 1'b1;
                        end else begin
                            r_res.bitan      <= i_norm_rsp.comp;
                            r_res.degenerate <= 1'b0;
                        end
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!o_valid || i_ready) begin
                        o_res   <= r_res;
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TTB_ASSERT_NOW(a_degen_zero, i_clk, i_rst_n, o_valid && o_res.degenerate, (o_res.tan == '0) && (o_res.bitan == '0), "degenerate result with nonzero vectors")
    `TTB_ASSERT_NOW(a_norm_done_waiting, i_clk, i_rst_n, i_norm_rsp.done, (r_state == S_WAIT_T) || (r_state == S_WAIT_B), "normalizer finished while not awaited")
    `TTB_ASSERT_NEXT(a_fin_loads, i_clk, i_rst_n, (r_state == S_FIN) && !o_valid, o_valid && (r_state == S_IDLE), "finished triangle not loaded to output")

endmodule

`default_nettype wire

FILE: hw/rtl/triangle_tangent_bitangent_top.sv
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent_top
// Per-triangle tangent and bitangent from a triangle-list vertex stream.
// ----------------------------------------------------------------------------
//
//  channel   dir  word                                      handshake
//  s_axis    in   one vertex: slot, position, texcoord      tvalid/tready
//  m_axis    out  one triangle: tangent, bitangent, slots   tvalid/tready
//
//  Vertices are taken one per cycle unless the front stalls; the front
//  holds corners one and two. The back runs each triangle's cross terms
//  on the shared multiplier, then up to two normalizer passes (tangent,
//  then bitangent), each dominated by the root and three divides.
//  A two-word queue sits between front and back; the front stalls on the
//  third corner only when that queue is full.
//  Reset is synchronous, active low, and clears the corner count, the queue
//  and the sequencer states and flags; held corners and data need no reset.
//
`timescale 1ns / 1ps
`default_nettype none

module triangle_tangent_bitangent_top #(
    parameter int SLOT_BITS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // vertex_slot, pos_x, pos_y, pos_z, tex_u, tex_v
    input  wire [ttb_pkg::IN_W-1:0]     i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  wire                         i_m_axis_tready,
    // tangent_x/y/z, bitangent_x/y/z, first_slot, second_slot, third_slot
    output logic [ttb_pkg::OUT_W-1:0]   o_m_axis_tdata,
    // degenerate
    output logic [0:0]                  o_m_axis_tuser
);

    ttb_pkg::t_tri      w_push_tri;
    ttb_pkg::t_tri      w_pop_tri;
    logic               w_push;
    logic               w_push_ready;
    logic               w_pop;
    logic               w_pop_valid;
    ttb_pkg::t_norm_req w_norm_req;
    ttb_pkg::t_norm_rsp w_norm_rsp;
    ttb_pkg::t_result   w_res;

    // Front: gather corners, form edges and deltas on the third.
    ttb_front #(
        .SLOT_BITS (SLOT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_data       (i_s_axis_tdata),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_tri        (w_push_tri)
    );

    // Decouple front from back.
    ttb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_tri),
        .o_ready (w_push_ready),
        .i_pop   (w_pop),
        .o_valid (w_pop_valid),
        .o_data  (w_pop_tri)
    );

    // Back: cross terms, determinant sign, normalizer requests and result word.
    ttb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tri_valid(w_pop_valid),
        .i_tri      (w_pop_tri),
        .o_pop      (w_pop),
        .o_norm_req (w_norm_req),
        .i_norm_rsp (w_norm_rsp),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_res      (w_res)
    );

    // Shared normalizer, used at most once for each vector.
    ttb_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_norm_req),
        .o_rsp   (w_norm_rsp)
    );

    // Pack the result word, first field lowest.
    assign o_m_axis_tdata = {w_res.slot, w_res.bitan, w_res.tan};
    assign o_m_axis_tuser = w_res.degenerate;

endmodule

`default_nettype wire

FILE: bench/tb_triangle_tangent_bitangent_top.sv
// ----------------------------------------------------------------------------
// tb_triangle_tangent_bitangent_top
// Self-checking bench for the per-triangle tangent/bitangent block: streams
// directed and random triangle-list vertices, predicts each triangle's unit
// vectors, slots and degenerate flag, and checks every output word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangle_tangent_bitangent_top;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 400;
    localparam int LONG_STALL  = 3000;
    localparam int RANDOM_TRIS = 442;

    typedef struct {
        logic [15:0]        slot;
        logic signed [31:0] px, py, pz, tu, tv;
        bit                 drain;  // hold until every triangle is out
    } vertex_t;

    typedef struct {
        logic [2:0][15:0] tan;
        logic [2:0][15:0] bitan;
        logic [2:0][15:0] slot;
        logic             degen;
    } tri_frame_t;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_valid = 1'b0;
    logic [ttb_pkg::IN_W-1:0]     s_data = '0;
    logic                         m_ready = 1'b0;
    wire                          s_ready;
    wire                          m_valid;
    wire [ttb_pkg::OUT_W-1:0]     m_data;
    wire [0:0]                    m_user;

    vertex_t    vertex_q[$];
    tri_frame_t frame_q[$];
    int         mismatches = 0;
    int         frames_seen = 0;
    int         cycles = 0;

    // Predictor copy of the held corners.
    longint     corner_pos[6];
    longint     corner_tex[4];
    logic [15:0] corner_slot[2];
    int         corner_cnt = 0;

    triangle_tangent_bitangent_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Exact difference, quartered with floor.
    function automatic longint quarter(input longint a, input longint b);
        longint d;
        d = a - b;
        return d >>> 2;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Scale a vector to Q1.14 unit length; zero vector returns 0.
    function automatic bit unit_vec(input longint c[3], output logic [2:0][15:0] o);
        longint unsigned mag[3], m, sum, len, q;
        int nbits;
        m = 0;
        sum = 0;
        nbits = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = c[i] < 0 ? longint'(-c[i]) : c[i];
            if (mag[i] > m) m = mag[i];
        end
        o = '0;
        if (m == 0) return 0;
        while (nbits < 64 && (m >> nbits) != 0) nbits++;
        for (int i = 0; i < 3; i++) begin
            if (nbits > 30) mag[i] = mag[i] >> (nbits - 30);
            else mag[i] = mag[i] << (30 - nbits);
            sum += mag[i] * mag[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 14) + len / 2) / len;
            o[i] = c[i] < 0 ? 16'(-q) : 16'(q);
        end
        return 1;
    endfunction

    // Take one accepted vertex; on the third corner queue the expected frame.
    task automatic accept_corner(input vertex_t v);
        longint p[3], e1[3], e2[3], tn[3], bt[3];
        longint du1, dv1, du2, dv2, det;
        tri_frame_t f;
        bit ok;
        p[0] = v.px;
        p[1] = v.py;
        p[2] = v.pz;
        if (corner_cnt < 2) begin
            for (int i = 0; i < 3; i++) corner_pos[corner_cnt*3+i] = p[i];
            corner_tex[corner_cnt*2]   = v.tu;
            corner_tex[corner_cnt*2+1] = v.tv;
            corner_slot[corner_cnt]    = v.slot;
            corner_cnt++;
            return;
        end
        corner_cnt = 0;
        for (int i = 0; i < 3; i++) begin
            e1[i] = quarter(corner_pos[3+i], corner_pos[i]);
            e2[i] = quarter(p[i], corner_pos[i]);
        end
        du1 = quarter(corner_tex[2], corner_tex[0]);
        dv1 = quarter(corner_tex[3], corner_tex[1]);
        du2 = quarter(v.tu, corner_tex[0]);
        dv2 = quarter(v.tv, corner_tex[1]);
        det = du1 * dv2 - du2 * dv1;
        for (int i = 0; i < 3; i++) begin
            tn[i] = dv2 * e1[i] - dv1 * e2[i];
            bt[i] = du1 * e2[i] - du2 * e1[i];
            if (det < 0) begin
                tn[i] = -tn[i];
                bt[i] = -bt[i];
            end
        end
        ok = det != 0;
        if (ok) ok = unit_vec(tn, f.tan);
        if (ok) ok = unit_vec(bt, f.bitan);
        if (!ok) begin
            f.tan   = '0;
            f.bitan = '0;
        end
        f.slot  = {v.slot, corner_slot[1], corner_slot[0]};
        f.degen = !ok;
        frame_q = {frame_q, f};
    endtask

    // Mostly no gap, sometimes short, rarely long; quiet stretches come from mode.
    function automatic int pick_gap(input bit busy);
        int r;
        r = $urandom_range(0, 99);
        if (!busy || r < 55) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2:    return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
            3:    return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000);
        endcase
    endfunction

    task automatic add_corner(input logic [15:0] slot, input logic [31:0] x, y, z, u, v,
                              input bit drain = 0);
        vertex_t c;
        c.slot = slot;
        c.px = x;
        c.py = y;
        c.pz = z;
        c.tu = u;
        c.tv = v;
        c.drain = drain;
        vertex_q = {vertex_q, c};
    endtask

    // Driver: advance to the next vertex when the current word is taken.
    bit send_busy = 1;
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) accept_corner(vertex_q.pop_front());
            if ($urandom_range(0, 149) == 0) send_busy = !send_busy;
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (vertex_q.size() > 0 &&
                             !(vertex_q[0].drain && frame_q.size() > 0)) begin
                    vertex_q[0].drain = 0;
                    s_data  <= {vertex_q[0].tv, vertex_q[0].tu, vertex_q[0].pz,
                                vertex_q[0].py, vertex_q[0].px, vertex_q[0].slot};
                    s_valid <= 1'b1;
                    send_gap = pick_gap(send_busy);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure plus one long hold-off to fill the block.
    bit recv_busy = 0;
    bit long_done = 0;
    int recv_hold = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (!long_done && frames_seen == 60) begin
                long_done = 1;
                recv_hold = LONG_STALL;
            end
            if ($urandom_range(0, 149) == 0) recv_busy = !recv_busy;
            if (recv_hold > 0) begin
                recv_hold--;
                m_ready <= 1'b0;
            end else begin
                recv_hold = pick_gap(recv_busy);
                m_ready <= (recv_hold == 0);
            end
        end
    end

    // Monitor: compare each output word with the oldest expected frame.
    always @(posedge i_clk) begin
        tri_frame_t f;
        if (i_rst_n && m_valid && m_ready) begin
            frames_seen++;
            if (frame_q.size() == 0) begin
                $error("unexpected output word %h", m_data);
                mismatches++;
            end else begin
                f = frame_q.pop_front();
                for (int i = 0; i < 3; i++) begin
                    if (m_data[16*i +: 16] !== f.tan[i]) begin
                        $error("tangent[%0d] expected %h got %h", i, f.tan[i],
                               m_data[16*i +: 16]);
                        mismatches++;
                    end
                    if (m_data[48+16*i +: 16] !== f.bitan[i]) begin
                        $error("bitangent[%0d] expected %h got %h", i, f.bitan[i],
                               m_data[48+16*i +: 16]);
                        mismatches++;
                    end
                    if (m_data[96+16*i +: 16] !== f.slot[i]) begin
                        $error("slot[%0d] expected %h got %h", i, f.slot[i],
                               m_data[96+16*i +: 16]);
                        mismatches++;
                    end
                end
                if (m_user[0] !== f.degen) begin
                    $error("degenerate expected %b got %b", f.degen, m_user[0]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Extremes: min/max corners and slot extremes.
        add_corner(16'h0000, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000);
        add_corner(16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 32'h80000000);
        add_corner(16'h8001, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h80000000, 32'h7FFFFFFF);
        // Zero determinant: all corners identical.
        repeat (3) add_corner(16'h1234, 0, 0, 0, 0, 0);
        // Zero-length vectors with a nonzero determinant.
        add_corner(16'h0001, 32'h10000, 32'h20000, 32'h30000, 0, 0);
        add_corner(16'h0002, 32'h10000, 32'h20000, 32'h30000, 32'h10000, 0);
        add_corner(16'h0003, 32'h10000, 32'h20000, 32'h30000, 0, 32'h10000);
        // Well-formed triangle, positive determinant.
        add_corner(16'h0010, 0, 0, 0, 0, 0);
        add_corner(16'h0011, 32'h10000, 0, 0, 32'h10000, 0);
        add_corner(16'h0012, 0, 32'h10000, 0, 0, 32'h10000);
        // Same, with mirrored texture: negative determinant.
        add_corner(16'h0020, 0, 0, 0, 0, 0);
        add_corner(16'h0021, 32'h10000, 0, 0, 0, 32'h10000);
        add_corner(16'h0022, 0, 32'h10000, 0, 32'h10000, 0);
        // Small deltas near the quarter rounding edge.
        add_corner(16'h7FFF, 32'hFFFFFFFF, 3, 32'hFFFFFFFD, 1, 32'hFFFFFFFF);
        add_corner(16'h00FF, 5, 32'hFFFFFFF9, 2, 32'hFFFFFFF5, 6);
        add_corner(16'hFF00, 32'hFFFFFFF6, 7, 9, 13, 32'hFFFFFFEE);
        // Wait out the block before going random.
        add_corner(16'hA5A5, $urandom, $urandom, $urandom, $urandom, $urandom, 1);
        add_corner(16'h5A5A, $urandom, $urandom, $urandom, $urandom, $urandom);
        add_corner(16'hC3C3, $urandom, $urandom, $urandom, $urandom, $urandom);

        for (int t = 0; t < RANDOM_TRIS; t++) begin
            for (int k = 0; k < 3; k++) begin
                add_corner(16'($urandom), pick_coord(), pick_coord(), pick_coord(),
                           pick_coord(), pick_coord(), (k == 0) && (t == 300));
            end
        end

        wait (vertex_q.size() == 0 && !s_valid);
        wait (frame_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && frame_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/ttb_pkg.sv
hw/rtl/ttb_front.sv
hw/rtl/ttb_fifo.sv
hw/rtl/ttb_norm.sv
hw/rtl/ttb_back.sv
hw/rtl/triangle_tangent_bitangent_top.sv
bench/tb_triangle_tangent_bitangent_top.sv
